// ----- hw/rtl/midpoint_ellipse_rasterizer_core_macros.svh -----
`ifndef MIDPOINT_ELLIPSE_RASTERIZER_CORE_MACROS_SVH
`define MIDPOINT_ELLIPSE_RASTERIZER_CORE_MACROS_SVH

// same-cycle implication, disabled during reset
`define MER_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle check");

// next-cycle implication, disabled during reset
`define MER_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle check");

`endif

// ----- hw/rtl/mer_pkg.sv -----
package mer_pkg;

  localparam int unsigned RADIUS_BITS_DEF = 10;
  localparam int unsigned COORD_W         = 13;
  localparam int unsigned ORIGIN_W        = 11;
  localparam int unsigned CENTER_W        = 11;
  localparam int unsigned CFG_ADDR_W      = 1;
  localparam int unsigned CFG_DATA_W      = 11;
  localparam int unsigned PH_W            = 3;

  localparam logic [CFG_ADDR_W-1:0] CFG_ORIGIN_X = 1'b0;
  localparam logic [CFG_ADDR_W-1:0] CFG_ORIGIN_Y = 1'b1;

  localparam logic [ORIGIN_W-1:0] ORIGIN_X_RST = 11'd320;
  localparam logic [ORIGIN_W-1:0] ORIGIN_Y_RST = 11'd240;

  localparam logic ACT_START = 1'b0;

  localparam logic [1:0] PIX_FIRST = 2'd0;
  localparam logic [1:0] PIX_XM_YB = 2'd1;
  localparam logic [1:0] PIX_XP_YB = 2'd2;
  localparam logic [1:0] PIX_LAST  = 2'd3;

  localparam logic [PH_W-1:0] PH_STEP = 3'd0;
  localparam logic [PH_W-1:0] PH_PX   = 3'd1;
  localparam logic [PH_W-1:0] PH_PY   = 3'd2;
  localparam logic [PH_W-1:0] PH_END  = 3'd3;
  localparam logic [PH_W-1:0] PH_IDLE = 3'd4;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_INIT_RX,
    ST_INIT_RY,
    ST_INIT_RXRY,
    ST_INIT_DEC,
    ST_SW_XX,
    ST_SW_YY,
    ST_SW_AX,
    ST_SW_BY,
    ST_SW_AB,
    ST_SW_SUB,
    ST_SW_QTR,
    ST_SW_FIX,
    ST_EMIT,
    ST_DONE
  } state_e;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_LOAD,
    OP_SNAP,
    OP_FINISH,
    OP_MUL_RX,
    OP_MUL_RY,
    OP_MUL_RXRY,
    OP_INIT_DEC,
    OP_MUL_XX,
    OP_SW_YY,
    OP_SW_AX,
    OP_SW_BY,
    OP_SW_AB,
    OP_SW_SUB,
    OP_SW_QTR,
    OP_SW_FIX,
    OP_UPD_STEP,
    OP_UPD_PX,
    OP_UPD_PY,
    OP_UPD_END
  } op_e;

  typedef struct packed {
    op_e        op;
    logic [1:0] pix;
    logic       show_done;
  } dp_cmd_t;

  typedef struct packed {
    logic finished;
    logic region_two;
    logic need_switch;
    logic y_neg;
  } dp_sts_t;

endpackage

// ----- hw/rtl/midpoint_ellipse_rasterizer_core.sv -----
// Midpoint ellipse rasterizer. Configure origin_x / origin_y (index 0 / 1) while idle.
// A start item (action 0) loads centre and radii, then runs the init states ST_INIT_RX,
// ST_INIT_RY, ST_INIT_RXRY and ST_INIT_DEC before the next input transfer; it produces
// no result. Each step item (action 1) then yields four pixel results, last set on the
// fourth: the item is taken and its four coordinates registered, then the pixels are
// handed out one per cycle while out_ready is high, as the decision update runs alongside.
// The step that enters region two first runs the switch states ST_SW_XX to ST_SW_FIX,
// which rebuild the decision value through the shared multiplier and adder. Once the curve
// is complete, or before any start, a step gives a single result with done_res and last set
// and pixel_valid low. Pixel coordinates wrap modulo 2^13.
module midpoint_ellipse_rasterizer_core #(
  parameter int unsigned RADIUS_BITS = mer_pkg::RADIUS_BITS_DEF
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   cfg_we_i,
  input  logic        [mer_pkg::CFG_ADDR_W-1:0]  cfg_addr_i,
  input  logic        [mer_pkg::CFG_DATA_W-1:0]  cfg_wdata_i,
  input  logic                                   in_valid_i,
  output logic                                   in_ready_o,
  input  logic                                   action_i,
  input  logic signed [mer_pkg::CENTER_W-1:0]    center_x_i,
  input  logic signed [mer_pkg::CENTER_W-1:0]    center_y_i,
  input  logic        [RADIUS_BITS-1:0]          radius_x_i,
  input  logic        [RADIUS_BITS-1:0]          radius_y_i,
  output logic                                   out_valid_o,
  input  logic                                   out_ready_i,
  output logic signed [mer_pkg::COORD_W-1:0]     pixel_x_o,
  output logic signed [mer_pkg::COORD_W-1:0]     pixel_y_o,
  output logic                                   pixel_valid_o,
  output logic                                   last_o,
  output logic                                   done_res_o
);

  import mer_pkg::*;

  dp_cmd_t dp_cmd;
  dp_sts_t dp_sts;

  mer_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .action_i      (action_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .pixel_valid_o (pixel_valid_o),
    .last_o        (last_o),
    .done_res_o    (done_res_o),
    .sts_i         (dp_sts),
    .cmd_o         (dp_cmd)
  );

  mer_dp #(
    .RADIUS_BITS (RADIUS_BITS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_wdata_i (cfg_wdata_i),
    .center_x_i  (center_x_i),
    .center_y_i  (center_y_i),
    .radius_x_i  (radius_x_i),
    .radius_y_i  (radius_y_i),
    .cmd_i       (dp_cmd),
    .sts_o       (dp_sts),
    .pixel_x_o   (pixel_x_o),
    .pixel_y_o   (pixel_y_o)
  );

endmodule

// ----- hw/rtl/mer_mul.sv -----
module mer_mul #(
  parameter int unsigned W = 2 * mer_pkg::RADIUS_BITS_DEF + 2
) (
  input  logic           clk_i,
  input  logic [W-1:0]   a_i,
  input  logic [W-1:0]   b_i,
  output logic [2*W-1:0] p_o
);

  logic [2*W-1:0] p_q;

  always_ff @(posedge clk_i) begin
    p_q <= a_i * b_i;
  end

  assign p_o = p_q;

endmodule

// ----- hw/rtl/mer_dp.sv -----
module mer_dp #(
  parameter int unsigned RADIUS_BITS = mer_pkg::RADIUS_BITS_DEF
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   cfg_we_i,
  input  logic        [mer_pkg::CFG_ADDR_W-1:0]  cfg_addr_i,
  input  logic        [mer_pkg::CFG_DATA_W-1:0]  cfg_wdata_i,
  input  logic signed [mer_pkg::CENTER_W-1:0]    center_x_i,
  input  logic signed [mer_pkg::CENTER_W-1:0]    center_y_i,
  input  logic        [RADIUS_BITS-1:0]          radius_x_i,
  input  logic        [RADIUS_BITS-1:0]          radius_y_i,
  input  mer_pkg::dp_cmd_t                       cmd_i,
  output mer_pkg::dp_sts_t                       sts_o,
  output logic signed [mer_pkg::COORD_W-1:0]     pixel_x_o,
  output logic signed [mer_pkg::COORD_W-1:0]     pixel_y_o
);

  import mer_pkg::*;

  localparam int unsigned XW    = RADIUS_BITS + 1;
  localparam int unsigned YW    = RADIUS_BITS + 2;
  localparam int unsigned SQ_W  = 2 * RADIUS_BITS;
  localparam int unsigned MUL_W = 2 * RADIUS_BITS + 2;
  localparam int unsigned DEC_W = 4 * RADIUS_BITS + 4;

  logic        [ORIGIN_W-1:0]    origin_x_q, origin_y_q;
  logic                          finished_q, in_r2_q;
  logic signed [CENTER_W-1:0]    hcx_q, hcy_q;
  logic        [RADIUS_BITS-1:0] hrx_q, hry_q;
  logic        [SQ_W-1:0]        rx2_q, ry2_q;
  logic        [XW-1:0]          cur_x_q;
  logic signed [YW-1:0]          cur_y_q;
  logic signed [DEC_W-1:0]       dec_q, acc_q, px_q, py_q;
  logic        [MUL_W-1:0]       acc2_q;
  logic                          incx_q, decy_q;
  logic signed [COORD_W-1:0]     xp_q, xm_q, ya_q, yb_q;

  logic        [MUL_W-1:0]       mul_a, mul_b;
  logic        [DEC_W-1:0]       mul_p;
  logic signed [DEC_W-1:0]       p_s, rx2_s, ry2_s, x_s, y_s;
  logic signed [DEC_W-1:0]       ox_s, oy_s, hcx_s, hcy_s, cx_s, cy_s;
  logic signed [YW-1:0]          ym_s, ym_abs;
  logic                          incx, decy, dec_pos;

  mer_mul #(
    .W (MUL_W)
  ) u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (mul_p)
  );

  assign p_s   = signed'(mul_p);
  assign rx2_s = signed'({{(DEC_W-SQ_W){1'b0}}, rx2_q});
  assign ry2_s = signed'({{(DEC_W-SQ_W){1'b0}}, ry2_q});
  assign x_s   = signed'({{(DEC_W-XW){1'b0}}, cur_x_q});
  assign y_s   = {{(DEC_W-YW){cur_y_q[YW-1]}}, cur_y_q};
  assign ox_s  = signed'({{(DEC_W-ORIGIN_W){1'b0}}, origin_x_q});
  assign oy_s  = signed'({{(DEC_W-ORIGIN_W){1'b0}}, origin_y_q});
  assign hcx_s = {{(DEC_W-CENTER_W){hcx_q[CENTER_W-1]}}, hcx_q};
  assign hcy_s = {{(DEC_W-CENTER_W){hcy_q[CENTER_W-1]}}, hcy_q};
  assign cx_s  = ox_s + hcx_s;
  assign cy_s  = oy_s - hcy_s;

  assign ym_s   = cur_y_q - signed'(YW'(1));
  assign ym_abs = ym_s[YW-1] ? -ym_s : ym_s;

  assign dec_pos = !dec_q[DEC_W-1] && (dec_q != '0);
  assign incx    = in_r2_q ? !dec_pos : 1'b1;
  assign decy    = in_r2_q ? 1'b1 : !dec_q[DEC_W-1];

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (cmd_i.op)
      OP_MUL_RX: begin
        mul_a = MUL_W'(hrx_q);
        mul_b = MUL_W'(hrx_q);
      end
      OP_MUL_RY: begin
        mul_a = MUL_W'(hry_q);
        mul_b = MUL_W'(hry_q);
      end
      OP_MUL_RXRY: begin
        mul_a = MUL_W'(rx2_q);
        mul_b = MUL_W'(hry_q);
      end
      OP_MUL_XX: begin
        mul_a = MUL_W'(cur_x_q);
        mul_b = MUL_W'(cur_x_q);
      end
      OP_SW_YY: begin
        mul_a = MUL_W'(ym_abs[XW-1:0]);
        mul_b = MUL_W'(ym_abs[XW-1:0]);
      end
      OP_SW_AX: begin
        mul_a = acc_q[MUL_W-1:0];
        mul_b = MUL_W'(ry2_q);
      end
      OP_SW_BY: begin
        mul_a = acc2_q;
        mul_b = MUL_W'(rx2_q);
      end
      OP_SW_AB: begin
        mul_a = MUL_W'(rx2_q);
        mul_b = MUL_W'(ry2_q);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      origin_x_q <= ORIGIN_X_RST;
      origin_y_q <= ORIGIN_Y_RST;
      finished_q <= 1'b1;
      in_r2_q    <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_addr_i)
          CFG_ORIGIN_X: origin_x_q <= cfg_wdata_i[ORIGIN_W-1:0];
          CFG_ORIGIN_Y: origin_y_q <= cfg_wdata_i[ORIGIN_W-1:0];
          default: ;
        endcase
      end
      unique case (cmd_i.op)
        OP_LOAD: begin
          finished_q <= 1'b0;
          in_r2_q    <= 1'b0;
        end
        OP_FINISH: finished_q <= 1'b1;
        OP_SW_FIX: in_r2_q    <= 1'b1;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (cmd_i.op)
      OP_LOAD: begin
        hcx_q   <= center_x_i;
        hcy_q   <= center_y_i;
        hrx_q   <= radius_x_i;
        hry_q   <= radius_y_i;
        cur_x_q <= '0;
        cur_y_q <= signed'(YW'(radius_y_i));
        px_q    <= '0;
      end
      OP_SNAP: begin
        xp_q <= COORD_W'(cx_s + x_s);
        xm_q <= COORD_W'(cx_s - x_s);
        ya_q <= COORD_W'(cy_s + y_s);
        yb_q <= COORD_W'(cy_s - y_s);
      end
      OP_MUL_RY:   rx2_q <= mul_p[SQ_W-1:0];
      OP_MUL_RXRY: ry2_q <= mul_p[SQ_W-1:0];
      OP_INIT_DEC: begin
        dec_q <= ry2_s - p_s + (rx2_s >>> 2);
        py_q  <= p_s <<< 1;
        px_q  <= '0;
      end
      OP_SW_YY:  acc_q  <= p_s + x_s;
      OP_SW_AX:  acc2_q <= mul_p[MUL_W-1:0];
      OP_SW_BY:  acc_q  <= p_s;
      OP_SW_AB:  acc_q  <= acc_q + p_s;
      OP_SW_SUB: acc_q  <= acc_q - p_s;
      OP_SW_QTR: acc_q  <= acc_q + (ry2_s >>> 2);
      OP_SW_FIX: begin
        dec_q <= acc_q + signed'(DEC_W'(acc_q[DEC_W-1] && (ry2_q[1:0] != 2'b00)));
      end
      OP_UPD_STEP: begin
        incx_q  <= incx;
        decy_q  <= decy;
        cur_x_q <= cur_x_q + {{(XW-1){1'b0}}, incx};
        cur_y_q <= cur_y_q - signed'({{(YW-1){1'b0}}, decy});
        if (incx) begin
          px_q <= px_q + (ry2_s <<< 1);
        end
        if (decy) begin
          py_q <= py_q - (rx2_s <<< 1);
        end
      end
      OP_UPD_PX: begin
        if (incx_q) begin
          dec_q <= dec_q + px_q;
        end
      end
      OP_UPD_PY: begin
        if (decy_q) begin
          dec_q <= dec_q - py_q;
        end
      end
      OP_UPD_END: begin
        if (!in_r2_q) begin
          dec_q <= dec_q + ry2_s;
        end else if (incx_q) begin
          dec_q <= dec_q - rx2_s;
        end else begin
          dec_q <= dec_q + rx2_s;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    pixel_x_o = '0;
    pixel_y_o = '0;
    if (!cmd_i.show_done) begin
      unique case (cmd_i.pix)
        PIX_FIRST: begin
          pixel_x_o = xp_q;
          pixel_y_o = ya_q;
        end
        PIX_XM_YB: begin
          pixel_x_o = xm_q;
          pixel_y_o = yb_q;
        end
        PIX_XP_YB: begin
          pixel_x_o = xp_q;
          pixel_y_o = yb_q;
        end
        PIX_LAST: begin
          pixel_x_o = xm_q;
          pixel_y_o = ya_q;
        end
        default: begin
          pixel_x_o = '0;
          pixel_y_o = '0;
        end
      endcase
    end
  end

  assign sts_o.finished    = finished_q;
  assign sts_o.region_two  = in_r2_q;
  assign sts_o.need_switch = !in_r2_q && !(px_q < py_q);
  assign sts_o.y_neg       = cur_y_q[YW-1];

endmodule

// ----- hw/rtl/mer_ctrl.sv -----
module mer_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic             action_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic             pixel_valid_o,
  output logic             last_o,
  output logic             done_res_o,
  input  mer_pkg::dp_sts_t sts_i,
  output mer_pkg::dp_cmd_t cmd_o
);

  import mer_pkg::*;

  state_e          state_q, state_d;
  logic [1:0]      pix_q, pix_d;
  logic [PH_W-1:0] ph_q, ph_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      pix_q   <= PIX_FIRST;
      ph_q    <= PH_IDLE;
    end else begin
      state_q <= state_d;
      pix_q   <= pix_d;
      ph_q    <= ph_d;
    end
  end

  always_comb begin
    state_d         = state_q;
    pix_d           = pix_q;
    ph_d            = ph_q;
    cmd_o.op        = OP_NONE;
    cmd_o.pix       = pix_q;
    cmd_o.show_done = 1'b0;
    in_ready_o      = 1'b0;
    out_valid_o     = 1'b0;
    pixel_valid_o   = 1'b0;
    last_o          = 1'b0;
    done_res_o      = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          if (action_i == ACT_START) begin
            cmd_o.op = OP_LOAD;
            state_d  = ST_INIT_RX;
          end else begin
            priority if (sts_i.finished) begin
              state_d = ST_DONE;
            end else if ((sts_i.region_two || sts_i.need_switch) && sts_i.y_neg) begin
              cmd_o.op = OP_FINISH;
              state_d  = ST_DONE;
            end else begin
              cmd_o.op = OP_SNAP;
              pix_d    = PIX_FIRST;
              ph_d     = PH_STEP;
              state_d  = sts_i.need_switch ? ST_SW_XX : ST_EMIT;
            end
          end
        end
      end
      ST_INIT_RX: begin
        cmd_o.op = OP_MUL_RX;
        state_d  = ST_INIT_RY;
      end
      ST_INIT_RY: begin
        cmd_o.op = OP_MUL_RY;
        state_d  = ST_INIT_RXRY;
      end
      ST_INIT_RXRY: begin
        cmd_o.op = OP_MUL_RXRY;
        state_d  = ST_INIT_DEC;
      end
      ST_INIT_DEC: begin
        cmd_o.op = OP_INIT_DEC;
        state_d  = ST_IDLE;
      end
      ST_SW_XX: begin
        cmd_o.op = OP_MUL_XX;
        state_d  = ST_SW_YY;
      end
      ST_SW_YY: begin
        cmd_o.op = OP_SW_YY;
        state_d  = ST_SW_AX;
      end
      ST_SW_AX: begin
        cmd_o.op = OP_SW_AX;
        state_d  = ST_SW_BY;
      end
      ST_SW_BY: begin
        cmd_o.op = OP_SW_BY;
        state_d  = ST_SW_AB;
      end
      ST_SW_AB: begin
        cmd_o.op = OP_SW_AB;
        state_d  = ST_SW_SUB;
      end
      ST_SW_SUB: begin
        cmd_o.op = OP_SW_SUB;
        state_d  = ST_SW_QTR;
      end
      ST_SW_QTR: begin
        cmd_o.op = OP_SW_QTR;
        state_d  = ST_SW_FIX;
      end
      ST_SW_FIX: begin
        cmd_o.op = OP_SW_FIX;
        state_d  = ST_EMIT;
      end
      ST_EMIT: begin
        out_valid_o   = 1'b1;
        pixel_valid_o = 1'b1;
        last_o        = (pix_q == PIX_LAST);
        unique case (ph_q)
          PH_STEP: cmd_o.op = OP_UPD_STEP;
          PH_PX:   cmd_o.op = OP_UPD_PX;
          PH_PY:   cmd_o.op = OP_UPD_PY;
          PH_END:  cmd_o.op = OP_UPD_END;
          default: cmd_o.op = OP_NONE;
        endcase
        if (ph_q != PH_IDLE) begin
          ph_d = ph_q + PH_W'(1);
        end
        if (out_ready_i) begin
          if (pix_q == PIX_LAST) begin
            state_d = ST_IDLE;
          end else begin
            pix_d = pix_q + 2'd1;
          end
        end
      end
      ST_DONE: begin
        out_valid_o     = 1'b1;
        last_o          = 1'b1;
        done_res_o      = 1'b1;
        cmd_o.show_done = 1'b1;
        if (out_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

// ----- hw/rtl/mer_checker.sv -----
`include "midpoint_ellipse_rasterizer_core_macros.svh"

module mer_checker (
  input logic                                clk_i,
  input logic                                rst_ni,
  input logic                                in_ready_o,
  input logic                                out_valid_o,
  input logic                                out_ready_i,
  input logic signed [mer_pkg::COORD_W-1:0]  pixel_x_o,
  input logic signed [mer_pkg::COORD_W-1:0]  pixel_y_o,
  input logic                                pixel_valid_o,
  input logic                                last_o,
  input logic                                done_res_o
);

  logic out_xfer;
  logic done_fmt;

  assign out_xfer = out_valid_o && out_ready_i;
  assign done_fmt = last_o && done_res_o && (pixel_x_o == '0) && (pixel_y_o == '0);

  `MER_ASSERT_NOW(a_done_format, clk_i, rst_ni, out_valid_o && !pixel_valid_o, done_fmt)
  `MER_ASSERT_NOW(a_pixel_not_done, clk_i, rst_ni, out_valid_o && pixel_valid_o, !done_res_o)
  `MER_ASSERT_NOW(a_no_overlap, clk_i, rst_ni, in_ready_o, !out_valid_o)
  `MER_ASSERT_NEXT(a_idle_after_last, clk_i, rst_ni, out_xfer && last_o, !out_valid_o && in_ready_o)

endmodule

bind midpoint_ellipse_rasterizer_core mer_checker u_mer_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_ready_o    (in_ready_o),
  .out_valid_o   (out_valid_o),
  .out_ready_i   (out_ready_i),
  .pixel_x_o     (pixel_x_o),
  .pixel_y_o     (pixel_y_o),
  .pixel_valid_o (pixel_valid_o),
  .last_o        (last_o),
  .done_res_o    (done_res_o)
);
